// ===== design/assert_macros.svh =====
// Assertion macros shared by the equalizer RTL.
// Depends on a clock named clk and an active-low reset named arst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check a property on every clock edge outside reset
`define OFPTE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check that a condition implies another in the next cycle
`define OFPTE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) ante |=> cons) else $error(msg);

`else

`define OFPTE_ASSERT(lbl, prop, msg)
`define OFPTE_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== design/ofpte_pkg.sv =====
// Shared types and constants of the pilot tap equalizer.
// No dependencies; used by ofpte_div and ofdm_pilot_tap_equalizer_unit.
`timescale 1ns / 1ps
`default_nettype none

package ofpte_pkg;

	// Field widths
	localparam int SAMPLE_W   = 16;
	localparam int FRAC_BITS  = 11;
	localparam int CARRIER_W  = 6;
	localparam int SET_IDX_W  = 2;
	localparam int NSETS_W    = 3;
	localparam int OFFSET_W   = 7;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 64;

	// Datapath widths
	localparam int PROD_W  = 2 * SAMPLE_W;
	localparam int SUM_W   = PROD_W + 1;
	localparam int MAG_W   = SUM_W + FRAC_BITS;
	localparam int DIV_W   = 3 * SAMPLE_W + 1;
	localparam int DIV_LAT = SAMPLE_W + 2;

	// Opcodes
	localparam logic [1:0] OP_LOAD_TAP   = 2'd0;
	localparam logic [1:0] OP_LOAD_PILOT = 2'd1;
	localparam logic [1:0] OP_EQUALIZE   = 2'd2;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_OCC_MASK = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_NUM_SETS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_OFFSET   = 2'd2;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	typedef struct packed {
		sample_t re;
		sample_t im;
	} cplx_t;

	typedef struct packed {
		logic [1:0]           opcode;
		logic [CARRIER_W-1:0] carrier_index;
		logic [SET_IDX_W-1:0] set_index;
		logic                 is_pilot;
		sample_t              sample_re;
		sample_t              sample_im;
	} in_item_t;

	typedef struct packed {
		logic [CARRIER_W-1:0] out_carrier;
		sample_t              out_re;
		sample_t              out_im;
		logic                 was_pilot;
		logic                 div_by_zero;
	} out_item_t;

	// One part of a complex division, sign and magnitude form
	typedef struct packed {
		logic [MAG_W-1:0]  mag;
		logic [PROD_W-1:0] den;
		logic              neg;
		logic              nz;
	} div_in_t;

	// Control and payload that travel beside the arithmetic
	typedef struct packed {
		logic                 op_tap;
		logic                 op_eq;
		logic [CARRIER_W-1:0] carrier;
		cplx_t                x;
		logic                 eq_div;
		logic                 pilot;
		cplx_t                sym;
		logic                 zero;
		logic                 rsv;
	} side_t;

endpackage

`default_nettype wire

// ===== design/ofpte_div.sv =====
// Pipelined restoring divider for one part of the complex quotient, one quotient bit per stage.
// Depends on ofpte_pkg; input register, one register per quotient bit, then output register; one operand per cycle.
`timescale 1ns / 1ps
`default_nettype none

module ofpte_div (
	input  logic                clk,
	input  ofpte_pkg::div_in_t  din,
	output ofpte_pkg::sample_t  quo
);

	localparam int QB = ofpte_pkg::SAMPLE_W;
	localparam int W  = ofpte_pkg::DIV_W;

	logic [W-1:0]                 rem_q [QB+1];
	logic [ofpte_pkg::PROD_W-1:0] den_q [QB+1];
	logic [QB-1:0]                q_q   [QB+1];
	logic                         ovf_q [QB+1];
	logic                         neg_q [QB+1];
	logic                         nz_q  [QB+1];

	// Register the operands and flag quotients that cannot fit the quotient bits at all
	always_ff @(posedge clk) begin
		rem_q[0] <= W'(din.mag);
		den_q[0] <= din.den;
		q_q[0]   <= '0;
		ovf_q[0] <= W'(din.mag) >= (W'(din.den) << QB);
		neg_q[0] <= din.neg;
		nz_q[0]  <= din.nz;
	end

	// One compare and subtract per stage, most significant bit first
	for (genvar i = 1; i <= QB; i++) begin : g_bit
		localparam int J = QB - i;
		logic [W-1:0] dsh;
		logic         take;

		assign dsh  = W'(den_q[i-1]) << J;
		assign take = rem_q[i-1] >= dsh;

		always_ff @(posedge clk) begin
			rem_q[i] <= take ? rem_q[i-1] - dsh : rem_q[i-1];
			den_q[i] <= den_q[i-1];
			q_q[i]   <= q_q[i-1] | (QB'(take) << J);
			ovf_q[i] <= ovf_q[i-1];
			neg_q[i] <= neg_q[i-1];
			nz_q[i]  <= nz_q[i-1];
		end
	end

	// Apply sign and saturate
	localparam ofpte_pkg::sample_t MAX_V = {1'b0, {(QB-1){1'b1}}};
	localparam ofpte_pkg::sample_t MIN_V = {1'b1, {(QB-1){1'b0}}};

	ofpte_pkg::sample_t mag_v;
	ofpte_pkg::sample_t res_v;

	assign mag_v = {1'b0, q_q[QB][QB-2:0]};

	always_comb begin
		if (!nz_q[QB]) begin
			res_v = '0;
		end else if (ovf_q[QB] || q_q[QB][QB-1]) begin
			res_v = neg_q[QB] ? MIN_V : MAX_V;
		end else begin
			res_v = neg_q[QB] ? -mag_v : mag_v;
		end
	end

	always_ff @(posedge clk) begin
		quo <= res_v;
	end

endmodule

`default_nettype wire

// ===== design/ofdm_pilot_tap_equalizer_unit.sv =====
// One-tap zero-forcing equalizer: one item accepted per cycle unless busy holds it back.
// The datapath is a 3-stage multiply/sum front end feeding two bit-per-stage dividers.
// A tap load or occupied equalize item waits while an earlier one on the same carrier is
// still in flight; in-order carrier streams never wait.
// Reset clears taps and pilot flags through per-entry valid bits at once; no clearing pass.
// Results leave on a one-cycle strobe; the receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none

module ofdm_pilot_tap_equalizer_unit #(
	parameter int FFT_LEN        = 64,
	parameter int MAX_PILOT_SETS = 4
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  ofpte_pkg::in_item_t                  item,
	output logic                                 done,
	output ofpte_pkg::out_item_t                 result,
	input  logic                                 cfg_we,
	input  logic [ofpte_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ofpte_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

	`include "assert_macros.svh"

	localparam int CW       = (FFT_LEN > 1) ? $clog2(FFT_LEN) : 1;
	localparam int SET_W    = (MAX_PILOT_SETS > 1) ? $clog2(MAX_PILOT_SETS) : 1;
	localparam int CNT_W    = SET_W + 1;
	localparam int PT_DEPTH = MAX_PILOT_SETS * FFT_LEN;
	localparam int PT_AW    = (PT_DEPTH > 1) ? $clog2(PT_DEPTH) : 1;
	localparam int SW       = ofpte_pkg::SAMPLE_W;
	localparam int PW       = ofpte_pkg::PROD_W;
	localparam int SUW      = ofpte_pkg::SUM_W;
	localparam int LAT      = ofpte_pkg::DIV_LAT;

	localparam logic [CNT_W-1:0] MAX_SETS_C = CNT_W'(MAX_PILOT_SETS);

	// Remainder of a small count, by shift and subtract
	function automatic logic [CNT_W-1:0] mod_small(input logic [CNT_W-1:0] a,
			input logic [CNT_W-1:0] b);
		logic [2*CNT_W-1:0] r;
		logic [2*CNT_W-1:0] t;
		r = (2*CNT_W)'(a);
		for (int j = CNT_W - 1; j >= 0; j--) begin
			t = (2*CNT_W)'(b) << j;
			if (r >= t) begin
				r = r - t;
			end
		end
		return r[CNT_W-1:0];
	endfunction

	// Configuration registers
	logic [ofpte_pkg::CFG_DATA_W-1:0] occ_q;
	logic [ofpte_pkg::NSETS_W-1:0]    nsets_q;
	logic [ofpte_pkg::OFFSET_W-1:0]   offs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q   <= '0;
			nsets_q <= '0;
			offs_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ofpte_pkg::CFG_OCC_MASK: occ_q   <= cfg_wdata;
				ofpte_pkg::CFG_NUM_SETS: nsets_q <= cfg_wdata[ofpte_pkg::NSETS_W-1:0];
				ofpte_pkg::CFG_OFFSET:   offs_q  <= cfg_wdata[ofpte_pkg::OFFSET_W-1:0];
				default: ;
			endcase
		end
	end

	logic [CNT_W-1:0] nsets_eff;
	assign nsets_eff = (int'(nsets_q) > MAX_PILOT_SETS) ? MAX_SETS_C : CNT_W'(nsets_q);

	// State
	logic [SET_W-1:0]    psn_q;
	logic [FFT_LEN-1:0]  pend_q;
	logic [FFT_LEN-1:0]  tap_vld_q;
	logic [PT_DEPTH-1:0] pt_flag_q;
	ofpte_pkg::cplx_t    tap_mem   [FFT_LEN];
	ofpte_pkg::cplx_t    pt_sym_mem [PT_DEPTH];

	// Decode the offered item
	logic [ofpte_pkg::CARRIER_W-1:0] k;
	logic [CW-1:0]                   k_a;
	logic                            k_ok;
	logic                            is_tap;
	logic                            is_plt;
	logic                            is_eq;
	logic                            occ;
	logic                            rsv_need;
	logic                            acc;
	logic signed [7:0]               idx;
	logic                            idx_ok;
	logic                            look;
	logic [PT_AW-1:0]                ra;
	logic [PT_AW-1:0]                wa;
	logic                            pt_we;
	logic                            plt_hit;

	assign k        = item.carrier_index;
	assign k_a      = k[CW-1:0];
	assign k_ok     = int'(k) < FFT_LEN;
	assign is_tap   = item.opcode == ofpte_pkg::OP_LOAD_TAP;
	assign is_plt   = item.opcode == ofpte_pkg::OP_LOAD_PILOT;
	assign is_eq    = item.opcode == ofpte_pkg::OP_EQUALIZE;
	assign occ      = k_ok && occ_q[k];
	assign rsv_need = k_ok && (is_tap || (is_eq && occ));

	// Hold off a tap access while an earlier one on that carrier is in flight
	assign busy = start && rsv_need && pend_q[k_a];
	assign acc  = start && !busy;

	assign idx     = $signed({2'b00, k}) - $signed({offs_q[ofpte_pkg::OFFSET_W-1], offs_q});
	assign idx_ok  = !idx[7] && (int'(idx) < FFT_LEN);
	assign look    = is_eq && occ && (nsets_eff != '0) && idx_ok;
	assign ra      = look ? PT_AW'(int'(psn_q) * FFT_LEN + int'(idx[6:0])) : '0;
	assign wa      = PT_AW'(int'(item.set_index) * FFT_LEN + int'(k));
	assign pt_we   = acc && is_plt && k_ok && (int'(item.set_index) < MAX_PILOT_SETS);
	assign plt_hit = look && pt_flag_q[ra];

	// Writeback side, driven from the end of the pipeline
	ofpte_pkg::side_t  wb;
	logic              wb_v;
	logic [CW-1:0]     wb_k;
	logic              tap_we;
	ofpte_pkg::cplx_t  tap_wd;
	ofpte_pkg::cplx_t  quot;

	// Advance the pilot set after the last carrier of a symbol
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			psn_q <= '0;
		end else if (acc && is_eq && (int'(k) == FFT_LEN - 1) && (nsets_eff != '0)) begin
			psn_q <= SET_W'(mod_small(CNT_W'(psn_q) + CNT_W'(1), nsets_eff));
		end
	end

	// Valid bits: pending tap updates, written taps, pilot flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q    <= '0;
			tap_vld_q <= '0;
			pt_flag_q <= '0;
		end else begin
			if (wb_v && wb.rsv) begin
				pend_q[wb_k] <= 1'b0;
			end
			if (acc && rsv_need) begin
				pend_q[k_a] <= 1'b1;
			end
			if (tap_we) begin
				tap_vld_q[wb_k] <= 1'b1;
			end
			if (pt_we) begin
				pt_flag_q[wa] <= item.is_pilot;
			end
		end
	end

	// Stage 1: register the item and the memory reads
	logic              vld_s1;
	ofpte_pkg::side_t  side_s1;
	ofpte_pkg::cplx_t  tap_rd_s1;
	logic              tapv_s1;
	ofpte_pkg::cplx_t  sym_s1;

	always_ff @(posedge clk) begin
		if (pt_we) begin
			pt_sym_mem[wa] <= {item.sample_re, item.sample_im};
		end
		sym_s1 <= pt_sym_mem[ra];
		if (tap_we) begin
			tap_mem[wb_k] <= tap_wd;
		end
		tap_rd_s1 <= tap_mem[k_a];
	end

	always_ff @(posedge clk) begin
		tapv_s1         <= tap_vld_q[k_a];
		side_s1.op_tap  <= is_tap;
		side_s1.op_eq   <= is_eq;
		side_s1.carrier <= k;
		side_s1.x       <= {item.sample_re, item.sample_im};
		side_s1.eq_div  <= is_eq && occ;
		side_s1.pilot   <= plt_hit;
		side_s1.sym     <= '0;
		side_s1.zero    <= 1'b0;
		side_s1.rsv     <= rsv_need;
	end

	// Stage 2: select the divisor and form the six products
	ofpte_pkg::cplx_t       tap_v;
	ofpte_pkg::cplx_t       dv;
	logic                   vld_s2;
	ofpte_pkg::side_t       side_n2;
	ofpte_pkg::side_t       side_s2;
	logic signed [PW-1:0]   ac_s2;
	logic signed [PW-1:0]   bd_s2;
	logic signed [PW-1:0]   bc_s2;
	logic signed [PW-1:0]   ad_s2;
	logic signed [PW-1:0]   cc_s2;
	logic signed [PW-1:0]   dd_s2;

	assign tap_v = tapv_s1 ? tap_rd_s1 : '0;
	assign dv    = side_s1.pilot ? sym_s1 : tap_v;

	// Attach the pilot symbol to the side data
	always_comb begin
		side_n2     = side_s1;
		side_n2.sym = sym_s1;
	end

	always_ff @(posedge clk) begin
		ac_s2   <= $signed(side_s1.x.re) * $signed(dv.re);
		bd_s2   <= $signed(side_s1.x.im) * $signed(dv.im);
		bc_s2   <= $signed(side_s1.x.im) * $signed(dv.re);
		ad_s2   <= $signed(side_s1.x.re) * $signed(dv.im);
		cc_s2   <= $signed(dv.re) * $signed(dv.re);
		dd_s2   <= $signed(dv.im) * $signed(dv.im);
		side_s2 <= side_n2;
	end

	// Stage 3: numerators and denominator
	logic                  vld_s3;
	ofpte_pkg::side_t      side_n3;
	ofpte_pkg::side_t      side_s3;
	logic signed [SUW-1:0] nr_s3;
	logic signed [SUW-1:0] ni_s3;
	logic [PW-1:0]         den_s3;
	logic [PW-1:0]         den_c;

	assign den_c = PW'(cc_s2) + PW'(dd_s2);

	// Attach the zero-divisor flag to the side data
	always_comb begin
		side_n3      = side_s2;
		side_n3.zero = den_c == '0;
	end

	always_ff @(posedge clk) begin
		nr_s3   <= $signed({ac_s2[PW-1], ac_s2}) + $signed({bd_s2[PW-1], bd_s2});
		ni_s3   <= $signed({bc_s2[PW-1], bc_s2}) - $signed({ad_s2[PW-1], ad_s2});
		den_s3  <= den_c;
		side_s3 <= side_n3;
	end

	// Sign and magnitude of the scaled numerators
	ofpte_pkg::div_in_t din_re;
	ofpte_pkg::div_in_t din_im;
	logic [SUW-1:0]     abs_re;
	logic [SUW-1:0]     abs_im;

	assign abs_re = nr_s3[SUW-1] ? SUW'(-nr_s3) : SUW'(nr_s3);
	assign abs_im = ni_s3[SUW-1] ? SUW'(-ni_s3) : SUW'(ni_s3);

	assign din_re.mag = {abs_re, {ofpte_pkg::FRAC_BITS{1'b0}}};
	assign din_re.den = den_s3;
	assign din_re.neg = nr_s3[SUW-1];
	assign din_re.nz  = nr_s3 != '0;
	assign din_im.mag = {abs_im, {ofpte_pkg::FRAC_BITS{1'b0}}};
	assign din_im.den = den_s3;
	assign din_im.neg = ni_s3[SUW-1];
	assign din_im.nz  = ni_s3 != '0;

	ofpte_pkg::sample_t q_re;
	ofpte_pkg::sample_t q_im;

	ofpte_div u_div_re (
		.clk (clk),
		.din (din_re),
		.quo (q_re)
	);

	ofpte_div u_div_im (
		.clk (clk),
		.din (din_im),
		.quo (q_im)
	);

	// Carry control beside the dividers
	ofpte_pkg::side_t side_q [LAT];
	logic [LAT-1:0]   vld_q;

	always_ff @(posedge clk) begin
		side_q[0] <= side_s3;
		for (int i = 1; i < LAT; i++) begin
			side_q[i] <= side_q[i-1];
		end
	end

	// Valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_q  <= '0;
		end else begin
			vld_s1 <= acc && (is_eq || (is_tap && k_ok));
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_q  <= {vld_q[LAT-2:0], vld_s3};
		end
	end

	// Writeback: update the tap and release the carrier
	assign wb     = side_q[LAT-1];
	assign wb_v   = vld_q[LAT-1];
	assign wb_k   = wb.carrier[CW-1:0];
	assign quot   = {q_re, q_im};
	assign tap_we = wb_v && (wb.op_tap || wb.pilot);
	assign tap_wd = wb.op_tap ? wb.x : quot;

	// Output register
	logic                 done_q;
	ofpte_pkg::out_item_t result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= wb_v && wb.op_eq;
		end
	end

	always_ff @(posedge clk) begin
		result_q.out_carrier <= wb.carrier;
		if (!wb.eq_div) begin
			result_q.out_re <= wb.x.re;
			result_q.out_im <= wb.x.im;
		end else if (wb.pilot) begin
			result_q.out_re <= wb.sym.re;
			result_q.out_im <= wb.sym.im;
		end else begin
			result_q.out_re <= q_re;
			result_q.out_im <= q_im;
		end
		result_q.was_pilot   <= wb.eq_div && wb.pilot;
		result_q.div_by_zero <= wb.eq_div && wb.zero;
	end

	assign done   = done_q;
	assign result = result_q;

	// Checks
	`OFPTE_ASSERT(a_wb_pending, wb_v && wb.rsv |-> pend_q[wb_k], "writeback of a carrier that was not reserved")
	`OFPTE_ASSERT_NEXT(a_rsv_sets, acc && rsv_need, pend_q[$past(k_a)], "accepted tap access did not reserve its carrier")
	`OFPTE_ASSERT(a_zero_pilot, done && result.was_pilot && result.div_by_zero |-> result.out_re == '0 && result.out_im == '0, "pilot with zero divisor gave a nonzero symbol")

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking bench for ofdm_pilot_tap_equalizer_unit: directed and random
// load/equalize items, with a bit-exact Q4.11 equalizer predictor inside.
// Depends on ofpte_pkg and the equalizer RTL.
`timescale 1ns / 1ps

module tb;

	localparam int NCAR = 64;
	localparam int NSET = 4;
	localparam int LAT  = 22;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	ofpte_pkg::in_item_t  item;
	logic                 done;
	ofpte_pkg::out_item_t result;
	logic                 cfg_we;
	logic [ofpte_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [ofpte_pkg::CFG_DATA_W-1:0] cfg_wdata;

	ofdm_pilot_tap_equalizer_unit dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	// Predictor state
	ofpte_pkg::cplx_t tap_mem [NCAR];
	logic             pil_flag [NSET*NCAR];
	ofpte_pkg::cplx_t pil_sym [NSET*NCAR];
	int unsigned      set_now;
	logic [63:0]      occ_mask;
	int unsigned      num_sets;
	int               car_offset;

	ofpte_pkg::in_item_t  pending_items[$];
	ofpte_pkg::out_item_t expected_eq[$];
	int        mismatch_count;
	int        eq_seen;
	int        sent_count;
	bit        stim_done;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50_000_000;
		$display("tb: failure");
		$finish;
	end

	task automatic report(input string what);
		mismatch_count++;
		$display("mismatch at %0t: %s", $time, what);
	endtask

	function automatic logic signed [15:0] sat16(input longint v);
		if (v > 32767)
			return 16'sh7fff;
		if (v < -32768)
			return 16'sh8000;
		return v[15:0];
	endfunction

	function automatic logic signed [15:0] part_quot(input longint n, input longint den);
		if (den == 0) begin
			if (n > 0)
				return 16'sh7fff;
			if (n < 0)
				return 16'sh8000;
			return '0;
		end
		return sat16((n * 2048) / den);
	endfunction

	function automatic ofpte_pkg::cplx_t cplx_quot(input ofpte_pkg::cplx_t x,
			input ofpte_pkg::cplx_t y, output logic zero);
		longint xr, xi, yr, yi, den;
		ofpte_pkg::cplx_t r;
		xr = x.re; xi = x.im; yr = y.re; yi = y.im;
		den = yr * yr + yi * yi;
		zero = (den == 0);
		r.re = part_quot(xr * yr + xi * yi, den);
		r.im = part_quot(xi * yr - xr * yi, den);
		return r;
	endfunction

	// Update predictor state for one accepted item; queue the expected result
	task automatic equalize_model(input ofpte_pkg::in_item_t it);
		int unsigned k;
		int idx;
		int unsigned ns, s;
		ofpte_pkg::cplx_t x, y, p;
		logic zero, pil;
		ofpte_pkg::out_item_t o;
		k = it.carrier_index;
		x.re = it.sample_re;
		x.im = it.sample_im;
		ns = (num_sets > NSET) ? NSET : num_sets;
		zero = 1'b0;
		pil = 1'b0;
		case (it.opcode)
			ofpte_pkg::OP_LOAD_TAP: begin
				tap_mem[k] = x;
			end
			ofpte_pkg::OP_LOAD_PILOT: begin
				pil_flag[it.set_index*NCAR+k] = it.is_pilot;
				pil_sym[it.set_index*NCAR+k] = x;
			end
			ofpte_pkg::OP_EQUALIZE: begin
				y = x;
				if (occ_mask[k]) begin
					idx = int'(k) - car_offset;
					s = set_now % NSET;
					if (ns != 0 && idx >= 0 && idx < NCAR && pil_flag[s*NCAR+idx]) begin
						p = pil_sym[s*NCAR+idx];
						tap_mem[k] = cplx_quot(x, p, zero);
						y = p;
						pil = 1'b1;
					end else begin
						y = cplx_quot(x, tap_mem[k], zero);
					end
				end
				if (k == NCAR-1 && ns != 0)
					set_now = (set_now + 1) % ns;
				o.out_carrier = 6'(k);
				o.out_re = y.re;
				o.out_im = y.im;
				o.was_pilot = pil;
				o.div_by_zero = zero;
				expected_eq.push_back(o);
			end
			default: ;
		endcase
	endtask

	// Driver: present queued items, with random gaps
	int gap_left;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			item <= '0;
			gap_left = 0;
		end else begin
			if (start && !busy) begin
				equalize_model(item);
				sent_count++;
			end
			if (start && busy) begin
				// hold the item until the transfer
			end else if (gap_left > 0) begin
				gap_left--;
				start <= 1'b0;
			end else if (pending_items.size() > 0) begin
				item <= pending_items.pop_front();
				start <= 1'b1;
				if ($urandom_range(0, 3) == 0)
					gap_left = ($urandom_range(0, 15) == 0) ? $urandom_range(5, 30)
						: $urandom_range(1, 3);
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: compare each result transfer with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_eq.size() == 0) begin
				report("result with nothing expected");
			end else begin
				ofpte_pkg::out_item_t e;
				e = expected_eq.pop_front();
				eq_seen++;
				if (result.out_carrier !== e.out_carrier)
					report($sformatf("carrier %0d exp %0d", result.out_carrier, e.out_carrier));
				if (result.out_re !== e.out_re)
					report($sformatf("re %0d exp %0d car %0d", result.out_re, e.out_re,
						e.out_carrier));
				if (result.out_im !== e.out_im)
					report($sformatf("im %0d exp %0d car %0d", result.out_im, e.out_im,
						e.out_carrier));
				if (result.was_pilot !== e.was_pilot)
					report($sformatf("was_pilot %b exp %b car %0d", result.was_pilot,
						e.was_pilot, e.out_carrier));
				if (result.div_by_zero !== e.div_by_zero)
					report($sformatf("div_by_zero %b exp %b car %0d", result.div_by_zero,
						e.div_by_zero, e.out_carrier));
			end
		end
	end

	function automatic ofpte_pkg::in_item_t mk(input logic [1:0] op, input int k, input int s,
			input int f, input int re, input int im);
		ofpte_pkg::in_item_t it;
		it.opcode = op;
		it.carrier_index = 6'(k);
		it.set_index = 2'(s);
		it.is_pilot = f[0];
		it.sample_re = 16'(re);
		it.sample_im = 16'(im);
		return it;
	endfunction

	function automatic int rnd_val();
		case ($urandom_range(0, 5))
			0: return 32767;
			1: return -32768;
			2: return 0;
			3: return $signed($urandom_range(0, 4095)) - 2048;
			default: return $signed(16'($urandom()));
		endcase
	endfunction

	// Write a register at a clock edge; predictor follows
	task automatic write_reg(input logic [ofpte_pkg::CFG_IDX_W-1:0] idx,
			input logic [63:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			ofpte_pkg::CFG_OCC_MASK: occ_mask = val;
			ofpte_pkg::CFG_NUM_SETS: num_sets = val[2:0];
			ofpte_pkg::CFG_OFFSET:   car_offset = $signed(val[6:0]);
			default: ;
		endcase
	endtask

	// Let queued items drain before touching the registers
	task automatic drain();
		int guard;
		guard = 0;
		while ((pending_items.size() > 0 || start || expected_eq.size() > 0)
				&& guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (LAT + 4) @(posedge clk);
	endtask

	task automatic random_phase(input int n);
		int sym_car;
		sym_car = 0;
		for (int i = 0; i < n; i++) begin
			int r;
			r = $urandom_range(0, 19);
			if (r == 0)
				pending_items.push_back(mk(ofpte_pkg::OP_LOAD_TAP, $urandom_range(0, 63), 0,
					$urandom_range(0, 1), rnd_val(), rnd_val()));
			else if (r == 1)
				pending_items.push_back(mk(ofpte_pkg::OP_LOAD_PILOT, $urandom_range(0, 63),
					$urandom_range(0, 3), $urandom_range(0, 1), rnd_val(), rnd_val()));
			else if (r == 2)
				pending_items.push_back(mk(2'd3, $urandom_range(0, 63), $urandom_range(0, 3),
					$urandom_range(0, 1), rnd_val(), rnd_val()));
			else if (r == 3)
				pending_items.push_back(mk(ofpte_pkg::OP_EQUALIZE, $urandom_range(0, 63),
					$urandom_range(0, 3), $urandom_range(0, 1), rnd_val(), rnd_val()));
			else begin
				// mostly in-order symbols
				pending_items.push_back(mk(ofpte_pkg::OP_EQUALIZE, sym_car,
					$urandom_range(0, 3), $urandom_range(0, 1), rnd_val(), rnd_val()));
				sym_car = (sym_car + 1) % NCAR;
			end
		end
	endtask

	initial begin
		for (int i = 0; i < NCAR; i++)
			tap_mem[i] = '0;
		for (int i = 0; i < NSET*NCAR; i++) begin
			pil_flag[i] = 1'b0;
			pil_sym[i] = '0;
		end
		set_now = 0; occ_mask = '0; num_sets = 0; car_offset = 0;
		mismatch_count = 0; eq_seen = 0; sent_count = 0; stim_done = 0;
		cfg_we = 1'b0; cfg_index = '0; cfg_wdata = '0;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		#1 arst_n = 1'b1;

		// Directed: unoccupied pass-through, zero-tap division, tap and pilot loads and an invalid opcode
		pending_items.push_back(mk(ofpte_pkg::OP_EQUALIZE, 5, 0, 0, 32767, -32768));
		drain();
		write_reg(ofpte_pkg::CFG_OCC_MASK, 64'hffff_ffff_ffff_ffff);
		write_reg(ofpte_pkg::CFG_NUM_SETS, 3'd2);
		write_reg(ofpte_pkg::CFG_OFFSET, 7'sd2);
		pending_items.push_back(mk(ofpte_pkg::OP_EQUALIZE, 1, 0, 0, 100, -100));
		pending_items.push_back(mk(ofpte_pkg::OP_EQUALIZE, 2, 0, 0, 0, 0));
		pending_items.push_back(mk(ofpte_pkg::OP_LOAD_TAP, 3, 0, 0, 2048, 0));
		pending_items.push_back(mk(ofpte_pkg::OP_LOAD_TAP, 4, 0, 0, 1, 1));
		pending_items.push_back(mk(ofpte_pkg::OP_LOAD_PILOT, 1, 0, 1, 2048, -2048));
		pending_items.push_back(mk(ofpte_pkg::OP_LOAD_PILOT, 2, 0, 1, 0, 0));
		pending_items.push_back(mk(ofpte_pkg::OP_LOAD_PILOT, 63, 3, 1, -32768, 32767));
		pending_items.push_back(mk(2'd3, 7, 1, 1, 1, 1));
		pending_items.push_back(mk(ofpte_pkg::OP_EQUALIZE, 3, 0, 0, 32767, -32768));
		pending_items.push_back(mk(ofpte_pkg::OP_EQUALIZE, 4, 0, 0, 32767, 32767));
		pending_items.push_back(mk(ofpte_pkg::OP_EQUALIZE, 4, 0, 0, -32768, 0));
		pending_items.push_back(mk(ofpte_pkg::OP_EQUALIZE, 3, 0, 0, 1000, 500));
		pending_items.push_back(mk(ofpte_pkg::OP_EQUALIZE, 4, 0, 0, 1000, 500));
		pending_items.push_back(mk(ofpte_pkg::OP_EQUALIZE, 0, 0, 0, 1, 1));
		pending_items.push_back(mk(ofpte_pkg::OP_EQUALIZE, 63, 0, 0, 1, 1));
		pending_items.push_back(mk(ofpte_pkg::OP_EQUALIZE, 3, 0, 0, 1, 1));
		pending_items.push_back(mk(ofpte_pkg::OP_EQUALIZE, 63, 0, 0, 1, 1));
		pending_items.push_back(mk(ofpte_pkg::OP_EQUALIZE, 3, 0, 0, 2048, 2048));
		drain();
		// Lowered set count, then the largest count
		write_reg(ofpte_pkg::CFG_NUM_SETS, 3'd1);
		pending_items.push_back(mk(ofpte_pkg::OP_EQUALIZE, 63, 0, 0, 9, 9));
		drain();
		write_reg(ofpte_pkg::CFG_NUM_SETS, 3'd7);
		write_reg(ofpte_pkg::CFG_OFFSET, 7'h60);

		// Random phases over several register settings
		for (int ph = 0; ph < 8; ph++) begin
			random_phase(250);
			drain();
			case (ph)
				0: write_reg(ofpte_pkg::CFG_OFFSET, 7'h20);
				1: write_reg(ofpte_pkg::CFG_OCC_MASK, {$urandom(), $urandom()});
				2: write_reg(ofpte_pkg::CFG_NUM_SETS, 3'd4);
				3: write_reg(ofpte_pkg::CFG_OFFSET, 7'h7f);
				4: write_reg(ofpte_pkg::CFG_NUM_SETS, 3'd0);
				5: write_reg(ofpte_pkg::CFG_OCC_MASK, 64'd0);
				6: begin
					write_reg(ofpte_pkg::CFG_OCC_MASK, 64'hffff_ffff_ffff_ffff);
					write_reg(ofpte_pkg::CFG_NUM_SETS, 3'd3);
					write_reg(ofpte_pkg::CFG_OFFSET, 7'd0);
				end
				default: ;
			endcase
		end
		drain();
		$display("covered %0d items, %0d equalized results checked, %0d mismatches",
			sent_count, eq_seen, mismatch_count);
		if (mismatch_count == 0 && expected_eq.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
